[sv/ttk_pkg.sv]
// Shared types, constants and character helpers for the keyword tokenizer.
`default_nettype none

package ttk_pkg;

    localparam int LINE_BITS     = 16;
    localparam int WORD_LEN_BITS = 8;
    localparam int KW_COUNT      = 5;
    localparam int KW_MAX_LEN    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_COMMENT = 2'd2
    } scan_mode_t;

    typedef enum logic [3:0] {
        TK_END          = 4'd0,
        TK_COLON        = 4'd1,
        TK_AT           = 4'd2,
        TK_COMMA        = 4'd3,
        TK_SEMICOLON    = 4'd4,
        TK_OPEN         = 4'd5,
        TK_CLOSE        = 4'd6,
        TK_KW_END       = 4'd7,
        TK_KW_PART_A    = 4'd8,
        TK_KW_PART_B    = 4'd9,
        TK_KW_PREF_A    = 4'd10,
        TK_KW_PREF_B    = 4'd11,
        TK_WORD         = 4'd12,
        TK_ERROR        = 4'd13
    } token_kind_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [7:0]  word_length;
        logic [15:0] line_num;
        logic [7:0]  error_char;
        logic        last;
    } token_t;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_OPEN      = 8'h28;
    localparam logic [7:0] CH_CLOSE     = 8'h29;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Keyword text, right-justified: the last character sits in bits [7:0].
    localparam logic [8*KW_MAX_LEN-1:0] KW_STR [KW_COUNT] = '{
        "End", "PartitionA", "PartitionB", "PreferenceListsA", "PreferenceListsB"
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 10, 10, 16, 16};
    localparam token_kind_t KW_KIND [KW_COUNT] = '{
        TK_KW_END, TK_KW_PART_A, TK_KW_PART_B, TK_KW_PREF_A, TK_KW_PREF_B
    };

    // Character at position pos of keyword k; valid only for pos below its length.
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [3:0] off;
        off = 4'(KW_LEN[k] - 1) - pos;
        return KW_STR[k][{off, 3'b000} +: 8];
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

`default_nettype wire

[sv/ttk_if.sv]
// Valid/ready channel interfaces for text bytes in and tokens out.
`default_nettype none

interface ttk_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ttk_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  word_length;
    logic [15:0] line_num;
    logic [7:0]  error_char;
    logic        last;

    modport source (output valid, output token_kind, output word_length,
                    output line_num, output error_char, output last, input ready);
    modport sink   (input valid, input token_kind, input word_length,
                    input line_num, input error_char, input last, output ready);
endinterface

`default_nettype wire

[sv/ttk_core.sv]
// Scanner state and per-byte token decode, up to two tokens per byte.
`default_nettype none

module ttk_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      char_code,
    input  logic            end_of_input,
    output ttk_pkg::token_t tok0,
    output ttk_pkg::token_t tok1,
    output logic [1:0]      tok_count
);
    import ttk_pkg::*;

    localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;
    localparam logic [WORD_LEN_BITS-1:0] WORD_MAX = '1;

    scan_mode_t               mode_reg,  mode_next;
    logic [WORD_LEN_BITS-1:0] count_reg, count_next;
    logic [KW_COUNT-1:0]      alive_reg, alive_next;
    logic [LINE_BITS-1:0]     line_reg,  line_next;

    logic [WORD_LEN_BITS-1:0] match_pos;
    logic [KW_COUNT-1:0]      match_mask;
    logic [15:0]              line_sat;
    logic [LINE_BITS-1:0]     line_bumped;
    logic [WORD_LEN_BITS-1:0] count_inc;
    token_t                   word_tok;
    token_t                   one_tok;
    logic                     has_one;
    logic                     flush;

    assign line_sat    = (32'(line_reg) > 32'hFFFF) ? 16'hFFFF : 16'(line_reg);
    assign line_bumped = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign count_inc   = (count_reg == WORD_MAX) ? count_reg : count_reg + 1'b1;
    assign match_pos   = (mode_reg == MODE_WORD) ? count_reg : '0;

    // Keep keyword k alive while the byte matches its character at this position.
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            match_mask[k] = (32'(match_pos) < 32'(KW_LEN[k])) &&
                            (kw_char(k, match_pos[3:0]) == char_code);
        end
    end

    // Token for the pending word; the lowest matching keyword wins.
    always_comb
    begin
        word_tok             = '0;
        word_tok.token_kind  = TK_WORD;
        word_tok.word_length = (32'(count_reg) > 32'hFF) ? 8'hFF : 8'(count_reg);
        word_tok.line_num    = line_sat;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (alive_reg[k] && (32'(count_reg) == 32'(KW_LEN[k])))
            begin
                word_tok.token_kind  = KW_KIND[k];
                word_tok.word_length = 8'd0;
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        alive_next = alive_reg;
        line_next  = line_reg;
        tok0       = '0;
        tok1       = '0;
        tok_count  = 2'd0;
        one_tok    = '0;
        one_tok.line_num = line_sat;
        has_one    = 1'b0;
        flush      = 1'b0;

        if (end_of_input)
        begin
            one_tok.token_kind = TK_END;
            one_tok.last       = 1'b1;
            if (mode_reg == MODE_WORD)
            begin
                tok0      = word_tok;
                tok1      = one_tok;
                tok_count = 2'd2;
            end
            else
            begin
                tok0      = one_tok;
                tok_count = 2'd1;
            end
            mode_next  = MODE_IDLE;
            count_next = '0;
            alive_next = '1;
            line_next  = LINE_BITS'(1);
        end
        else if (mode_reg == MODE_COMMENT)
        begin
            if (char_code == CH_NEWLINE)
            begin
                mode_next = MODE_IDLE;
                line_next = line_bumped;
            end
        end
        else if ((mode_reg == MODE_WORD) && (is_alnum(char_code) || char_code == CH_PLUS))
        begin
            alive_next = alive_reg & match_mask;
            count_next = count_inc;
        end
        else
        begin
            // Close any pending word, then handle the byte on its own.
            flush      = (mode_reg == MODE_WORD);
            mode_next  = MODE_IDLE;
            count_next = '0;
            alive_next = '1;
            priority if (is_space(char_code))
            begin
                if (char_code == CH_NEWLINE)
                    line_next = line_bumped;
            end
            else if (char_code == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (char_code == CH_COLON)
            begin
                one_tok.token_kind = TK_COLON;
                has_one = 1'b1;
            end
            else if (char_code == CH_AT)
            begin
                one_tok.token_kind = TK_AT;
                has_one = 1'b1;
            end
            else if (char_code == CH_COMMA)
            begin
                one_tok.token_kind = TK_COMMA;
                has_one = 1'b1;
            end
            else if (char_code == CH_SEMICOLON)
            begin
                one_tok.token_kind = TK_SEMICOLON;
                has_one = 1'b1;
            end
            else if (char_code == CH_OPEN)
            begin
                one_tok.token_kind = TK_OPEN;
                has_one = 1'b1;
            end
            else if (char_code == CH_CLOSE)
            begin
                one_tok.token_kind = TK_CLOSE;
                has_one = 1'b1;
            end
            else if (is_alnum(char_code))
            begin
                mode_next  = MODE_WORD;
                count_next = WORD_LEN_BITS'(1);
                alive_next = match_mask;
            end
            else
            begin
                one_tok.token_kind = TK_ERROR;
                one_tok.error_char = char_code;
                has_one = 1'b1;
            end

            one_tok.last = 1'b1;
            if (flush)
            begin
                tok0      = word_tok;
                tok0.last = !has_one;
                tok1      = one_tok;
                tok_count = has_one ? 2'd2 : 2'd1;
            end
            else
            begin
                tok0      = one_tok;
                tok_count = has_one ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            alive_reg <= '1;
            line_reg  <= LINE_BITS'(1);
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            alive_reg <= alive_next;
            line_reg  <= line_next;
        end
    end

endmodule

`default_nettype wire

[sv/ttk_out_fifo.sv]
// Small token queue that takes up to two tokens a cycle and hands out one.
`default_nettype none

module ttk_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_count,
    input  ttk_pkg::token_t push0,
    input  ttk_pkg::token_t push1,
    output logic            room2,
    output logic            head_valid,
    input  logic            head_ready,
    output ttk_pkg::token_t head
);
    import ttk_pkg::*;

    token_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;

    assign head_valid   = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = head_valid && head_ready;
    assign room2        = (32'(count_reg) <= QUEUE_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

endmodule

`default_nettype wire

[sv/text_tokenizer_keywords.sv]
// Top level of the streaming keyword tokenizer.
//
// char_in takes one text byte per beat (char_code), or an end-of-stream mark
// (end_of_input) that flushes any pending word, emits an end token and
// returns the scanner to its reset state. token_out gives one token per beat;
// the last token caused by a byte carries last = 1, and bytes that only move
// the scanner (whitespace, comment text, word characters) give none.
// A byte is held in the byte register and decoded there by the scanner; its
// tokens are written into the token queue, whose head drives token_out.
// Throughput: one byte per cycle. A byte that both ends a word and yields
// a token of its own pushes two tokens, but it always follows a word byte
// that pushes none, so the four-entry token queue keeps up and the input never
// stalls while the receiver takes a token every cycle. The byte register takes
// a byte whenever it is empty or its byte moves on, so the input stays ready
// while a token waits on a stalled receiver, until the queue lacks room for
// two more tokens.
// Reset clears the byte register, the queue and the scanner: idle mode,
// empty word, all keywords alive, line one.
`default_nettype none

module text_tokenizer_keywords (
    input  logic       clk,
    input  logic       rst_n,
    ttk_char_if.sink   char_in,
    ttk_token_if.source token_out
);
    import ttk_pkg::*;

    logic       byte_valid_reg;
    logic [7:0] byte_char_reg;
    logic       byte_eoi_reg;
    logic       room2;
    logic       advance;
    token_t     tok0;
    token_t     tok1;
    logic [1:0] tok_count;
    logic [1:0] push_count;
    token_t     head;

    assign advance       = byte_valid_reg && room2;
    assign char_in.ready = !byte_valid_reg || room2;
    assign push_count    = advance ? tok_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (char_in.ready)
            byte_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            byte_char_reg <= char_in.char_code;
            byte_eoi_reg  <= char_in.end_of_input;
        end
    end

    ttk_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .char_code    (byte_char_reg),
        .end_of_input (byte_eoi_reg),
        .tok0         (tok0),
        .tok1         (tok1),
        .tok_count    (tok_count)
    );

    ttk_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (tok0),
        .push1      (tok1),
        .room2      (room2),
        .head_valid (token_out.valid),
        .head_ready (token_out.ready),
        .head       (head)
    );

    assign token_out.token_kind  = head.token_kind;
    assign token_out.word_length = head.word_length;
    assign token_out.line_num    = head.line_num;
    assign token_out.error_char  = head.error_char;
    assign token_out.last        = head.last;

endmodule

`default_nettype wire

[sv/ttk_checker.sv]
// Port-level checks on the token channel, bound to the tokenizer top level.
`default_nettype none

module ttk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [3:0]  token_kind,
    input logic [7:0]  word_length,
    input logic [15:0] line_num,
    input logic [7:0]  error_char,
    input logic        last
);
    import ttk_pkg::*;

    // Hold a stalled token.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(token_kind) && $stable(line_num) &&
                            $stable(word_length))
        else $error("token changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_kind == TK_END) |-> last)
        else $error("end token without last");

    a_len_word_only: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_kind != TK_WORD) |-> (word_length == 8'd0))
        else $error("nonzero length on a non-word token");

    a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_kind != TK_ERROR) |-> (error_char == 8'd0))
        else $error("error byte on a non-error token");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (line_num != 16'd0))
        else $error("line number zero");

endmodule

bind text_tokenizer_keywords ttk_checker u_ttk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (token_out.valid),
    .ready       (token_out.ready),
    .token_kind  (token_out.token_kind),
    .word_length (token_out.word_length),
    .line_num    (token_out.line_num),
    .error_char  (token_out.error_char),
    .last        (token_out.last)
);

`default_nettype wire
